/* hw/rtl/lcdfb_pkg.sv */
// ----------------------------------------------------------------------------
// lcdfb_pkg
// Shared codes and transaction types of the character LCD text frame buffer.
// ----------------------------------------------------------------------------
package lcdfb_pkg;

	// Commands carried by an input transaction.
	localparam logic [1:0] CMD_PUT     = 2'd0;
	localparam logic [1:0] CMD_CLEAR   = 2'd1;
	localparam logic [1:0] CMD_SETCUR  = 2'd2;
	localparam logic [1:0] CMD_REFRESH = 2'd3;

	// Kinds of result transaction.
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_CMD    = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;

	localparam logic [7:0] HOME_CMD = 8'h02;
	localparam logic [7:0] SPACE    = 8'd32;
	localparam logic [7:0] NEWLINE  = 8'd10;

	// Column field of a classified command; wide enough for up to 64 columns.
	localparam int COL_BITS = 6;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [7:0]          ch;
		logic                nl;
		logic                bad;
		logic [COL_BITS-1:0] col;
		logic [1:0]          row;
	} op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       status;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic [7:0] byte_c;
		logic [7:0] byte_d;
		logic       last;
	} res_t;

endpackage

/* hw/rtl/lcdfb_front.sv */
// ----------------------------------------------------------------------------
// lcdfb_front
// Accepts commands, maps glyphs, checks cursor positions and queues the
// classified commands for the execution side.
// ----------------------------------------------------------------------------
module lcdfb_front #(
	parameter int COLUMNS = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      command,
	input  logic [7:0]      char_code,
	input  logic [7:0]      col,
	input  logic [7:0]      row,
	output logic            op_valid,
	output lcdfb_pkg::op_t  op,
	input  logic            op_take
);

	lcdfb_pkg::op_t ops_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;
	lcdfb_pkg::op_t op_in;
	logic [7:0]     mapped;
	logic           accept;

	function automatic logic [7:0] map_glyph(input logic [7:0] c);
		logic [7:0] g;
		case (c)
			8'ha5:   g = 8'h02;
			8'h86:   g = 8'h03;
			8'ha9:   g = 8'h04;
			8'ha2:   g = 8'h05;
			8'h88:   g = 8'h06;
			8'he4:   g = 8'h00;
			8'h98:   g = 8'h07;
			default: g = c;
		endcase
		return g;
	endfunction

	always_comb begin
		mapped     = map_glyph(char_code);
		op_in.cmd  = command;
		op_in.ch   = mapped;
		op_in.nl   = (mapped == lcdfb_pkg::NEWLINE);
		op_in.bad  = (col >= 8'(COLUMNS)) || (row > 8'd3);
		op_in.col  = col[lcdfb_pkg::COL_BITS-1:0];
		op_in.row  = row[1:0];
	end

	assign full     = (cnt_q == 2'd2);
	assign accept   = push && !full;
	assign op_valid = (cnt_q != 2'd0);
	assign op       = ops_q[rptr_q];

	always_ff @(posedge clk) begin
		if (accept) ops_q[wptr_q] <= op_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (accept) wptr_q <= !wptr_q;
			if (op_take) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, accept} - {1'b0, op_take};
		end
	end

endmodule

/* hw/rtl/lcdfb_resq.sv */
// ----------------------------------------------------------------------------
// lcdfb_resq
// Two-entry result queue between the execution side and the result port.
// ----------------------------------------------------------------------------
module lcdfb_resq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_push,
	input  lcdfb_pkg::res_t res_in,
	output logic            res_full,
	output logic            empty,
	input  logic            pop,
	output lcdfb_pkg::res_t res_out
);

	lcdfb_pkg::res_t ents_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      cnt_q;
	logic            take;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign take     = pop && !empty;
	assign res_out  = ents_q[rptr_q];

	always_ff @(posedge clk) begin
		if (res_push) ents_q[wptr_q] <= res_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (res_push) wptr_q <= !wptr_q;
			if (take) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, take};
		end
	end

endmodule

/* hw/rtl/lcdfb_exec.sv */
// ----------------------------------------------------------------------------
// lcdfb_exec
// Executes classified commands: owns the character store and the cursor, and
// walks the store in display memory order for a refresh.
// ----------------------------------------------------------------------------
module lcdfb_exec #(
	parameter int COLUMNS = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	input  lcdfb_pkg::op_t  op,
	output logic            op_take,
	input  logic            res_full,
	output logic            res_push,
	output lcdfb_pkg::res_t res_in
);

	localparam int DEPTH = 4 * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLUMNS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]       state_q;
	logic [CW-1:0]    cur_col_q;
	logic [1:0]       cur_row_q;
	logic [DEPTH-1:0] valid_q;
	logic             fill_q;
	logic [1:0]       seg_q;
	logic [CW-1:0]    cc_q;
	logic [1:0]       bsel_q;
	logic [7:0]       gbuf_q [3];

	logic [7:0]       mem [DEPTH];
	logic [7:0]       rd_data_s1;
	logic             rd_valid_s1;
	logic             rd_vld_s1;
	logic [1:0]       rd_pos_s1;
	logic             rd_last_s1;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic             rd_issue;
	logic             final_issue;
	logic             ret_push;
	logic [7:0]       ret_byte;
	logic [1:0]       walk_row;
	logic             col_wrap;

	function automatic logic [AW-1:0] addr_of(input logic [1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(COLUMNS) + AW'(c);
	endfunction

	// Display memory holds rows 0 and 2 in its first line, 1 and 3 in its second.
	always_comb begin
		case (seg_q)
			2'd0:    walk_row = 2'd0;
			2'd1:    walk_row = 2'd2;
			2'd2:    walk_row = 2'd1;
			default: walk_row = 2'd3;
		endcase
	end

	assign waddr       = addr_of(cur_row_q, cur_col_q);
	assign raddr       = addr_of(walk_row, cc_q);
	assign final_issue = (seg_q == 2'd3) && (cc_q == CW'(COLUMNS - 1));
	assign col_wrap    = (cur_col_q == CW'(COLUMNS - 1));
	assign ret_byte    = rd_valid_s1 ? rd_data_s1 : (fill_q ? lcdfb_pkg::SPACE : 8'd0);
	assign ret_push    = rd_vld_s1 && (rd_pos_s1 == 2'd3);

	always_comb begin
		op_take  = 1'b0;
		res_push = 1'b0;
		we       = 1'b0;
		rd_issue = 1'b0;
		res_in   = '0;
		res_in.kind = lcdfb_pkg::KIND_STATUS;
		case (state_q)
			ST_IDLE: begin
				if (op_valid && !res_full) begin
					op_take     = 1'b1;
					res_push    = 1'b1;
					res_in.last = 1'b1;
					case (op.cmd)
						lcdfb_pkg::CMD_PUT:    we = !op.nl;
						lcdfb_pkg::CMD_SETCUR: res_in.status = op.bad;
						lcdfb_pkg::CMD_REFRESH: begin
							res_in.kind   = lcdfb_pkg::KIND_CMD;
							res_in.byte_a = lcdfb_pkg::HOME_CMD;
							res_in.last   = 1'b0;
						end
						default: ;
					endcase
				end
			end
			ST_WALK, ST_DRAIN: begin
				if (ret_push) begin
					res_push      = 1'b1;
					res_in.kind   = lcdfb_pkg::KIND_DATA;
					res_in.byte_a = gbuf_q[0];
					res_in.byte_b = gbuf_q[1];
					res_in.byte_c = gbuf_q[2];
					res_in.byte_d = ret_byte;
					res_in.last   = rd_last_s1;
				end
				// The read that completes a group goes out only when the queue
				// can take that group in the following cycle.
				if (state_q == ST_WALK) begin
					rd_issue = (bsel_q != 2'd3) || (!res_full && !ret_push);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= op.ch;
		rd_data_s1  <= mem[raddr];
		rd_valid_s1 <= valid_q[raddr];
		if (rd_vld_s1 && (rd_pos_s1 != 2'd3)) gbuf_q[rd_pos_s1] <= ret_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_col_q  <= '0;
			cur_row_q  <= 2'd0;
			valid_q    <= '0;
			fill_q     <= 1'b0;
			seg_q      <= 2'd0;
			cc_q       <= '0;
			bsel_q     <= 2'd0;
			rd_vld_s1  <= 1'b0;
			rd_pos_s1  <= 2'd0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= rd_issue;
			rd_pos_s1  <= bsel_q;
			rd_last_s1 <= final_issue;
			case (state_q)
				ST_IDLE: begin
					if (op_take) begin
						case (op.cmd)
							lcdfb_pkg::CMD_PUT: begin
								if (op.nl || col_wrap) begin
									cur_col_q <= '0;
									cur_row_q <= cur_row_q + 2'd1;
								end else begin
									cur_col_q <= cur_col_q + CW'(1);
								end
								if (!op.nl) valid_q[waddr] <= 1'b1;
							end
							lcdfb_pkg::CMD_CLEAR: begin
								valid_q   <= '0;
								fill_q    <= 1'b1;
								cur_col_q <= '0;
								cur_row_q <= 2'd0;
							end
							lcdfb_pkg::CMD_SETCUR: begin
								if (!op.bad) begin
									cur_col_q <= op.col[CW-1:0];
									cur_row_q <= op.row;
								end
							end
							default: begin
								state_q <= ST_WALK;
								seg_q   <= 2'd0;
								cc_q    <= '0;
								bsel_q  <= 2'd0;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (rd_issue) begin
						bsel_q <= bsel_q + 2'd1;
						if (cc_q == CW'(COLUMNS - 1)) begin
							cc_q  <= '0;
							seg_q <= seg_q + 2'd1;
						end else begin
							cc_q <= cc_q + CW'(1);
						end
						if (final_issue) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (ret_push) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/char_lcd_text_frame_buffer_unit.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_frame_buffer_unit
// Text frame buffer and cursor for a four-row HD44780-style character LCD.
// ----------------------------------------------------------------------------
// Put character, clear and set cursor each give one status transaction. A
// refresh gives a cursor-home command transaction and then COLUMNS data
// transactions of four bytes; the store has a single read port, so the walk
// reads one byte a cycle while the result queue has room for each group, and
// a refresh holds the execution side until its last group is pushed. A
// two-entry command queue lets further commands be accepted meanwhile. Clear
// takes effect at once via per-character valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module char_lcd_text_frame_buffer_unit #(
	parameter int COLUMNS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] command,
	input  logic [7:0] char_code,
	input  logic [7:0] col,
	input  logic [7:0] row,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] kind,
	output logic       status,
	output logic [7:0] byte_a,
	output logic [7:0] byte_b,
	output logic [7:0] byte_c,
	output logic [7:0] byte_d,
	output logic       last
);

	logic            op_valid;
	lcdfb_pkg::op_t  op;
	logic            op_take;
	logic            res_full;
	logic            res_push;
	lcdfb_pkg::res_t res_in;
	lcdfb_pkg::res_t res_out;

	lcdfb_front #(.COLUMNS(COLUMNS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.char_code (char_code),
		.col       (col),
		.row       (row),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take)
	);

	lcdfb_exec #(.COLUMNS(COLUMNS)) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take),
		.res_full (res_full),
		.res_push (res_push),
		.res_in   (res_in)
	);

	lcdfb_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign kind   = res_out.kind;
	assign status = res_out.status;
	assign byte_a = res_out.byte_a;
	assign byte_b = res_out.byte_b;
	assign byte_c = res_out.byte_c;
	assign byte_d = res_out.byte_d;
	assign last   = res_out.last;

`ifndef SYNTHESIS
	// A rejected cursor position only ever appears on a status transaction.
	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> (kind == lcdfb_pkg::KIND_STATUS))
		else $error("rejection flag on a non-status result");

	// The home command never ends a refresh.
	a_home_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == lcdfb_pkg::KIND_CMD)) |-> !last)
		else $error("home command marked as final result");

	// The execution side never pushes into a full result queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_full |-> !res_push)
		else $error("result queue overflow");

	// A command is only taken from a non-empty command queue.
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |-> op_valid)
		else $error("command taken from empty queue");
`endif

endmodule

/* tb/sv/lcdfb_text_checker.sv */
// ----------------------------------------------------------------------------
// lcdfb_text_checker
// Watches both queue interfaces of the text frame buffer, predicts every
// result transaction from the accepted commands and compares them in order.
// ----------------------------------------------------------------------------
module lcdfb_text_checker #(
	parameter int COLUMNS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [1:0] command,
	input  logic [7:0] char_code,
	input  logic [7:0] col,
	input  logic [7:0] row,
	input  logic       empty,
	input  logic       pop,
	input  logic [1:0] kind,
	input  logic       status,
	input  logic [7:0] byte_a,
	input  logic [7:0] byte_b,
	input  logic [7:0] byte_c,
	input  logic [7:0] byte_d,
	input  logic       last,
	output int         fail_count,
	output int         pending_count,
	output int         checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS  = COLUMNS * 4;
	localparam int GROUPS = CELLS / 4;

	logic [7:0]      char_ram [CELLS];
	logic [5:0]      cur_col;
	logic [1:0]      cur_row;
	lcdfb_pkg::res_t frames_due [$];
	lcdfb_pkg::res_t oldest;

	function automatic logic [7:0] glyph_of(logic [7:0] raw);
		case (raw)
		8'ha5: return 8'h02;
		8'h86: return 8'h03;
		8'ha9: return 8'h04;
		8'ha2: return 8'h05;
		8'h88: return 8'h06;
		8'he4: return 8'h00;
		8'h98: return 8'h07;
		default: return raw;
		endcase
	endfunction

	task automatic advance_row();
		cur_col = '0;
		cur_row = cur_row + 2'd1;
	endtask

	task automatic predict_command(logic [1:0] cmd, logic [7:0] ch, logic [7:0] c,
			logic [7:0] r);
		lcdfb_pkg::res_t rs;
		logic [7:0]      glyph;
		logic [7:0]      grp [4];
		logic [1:0]      seg;
		logic [1:0]      ram_row;
		int              n;
		rs = '0;
		rs.last = 1'b1;
		case (cmd)
		lcdfb_pkg::CMD_PUT: begin
			glyph = glyph_of(ch);
			if (glyph == lcdfb_pkg::NEWLINE) begin
				advance_row();
			end else begin
				char_ram[int'(cur_row) * COLUMNS + int'(cur_col)] = glyph;
				if (int'(cur_col) == COLUMNS - 1)
					advance_row();
				else
					cur_col = cur_col + 6'd1;
			end
			frames_due.push_back(rs);
		end
		lcdfb_pkg::CMD_CLEAR: begin
			foreach (char_ram[i])
				char_ram[i] = lcdfb_pkg::SPACE;
			cur_col = '0;
			cur_row = '0;
			frames_due.push_back(rs);
		end
		lcdfb_pkg::CMD_SETCUR: begin
			if (c >= COLUMNS || r >= 4) begin
				rs.status = 1'b1;
			end else begin
				cur_col = c[5:0];
				cur_row = r[1:0];
			end
			frames_due.push_back(rs);
		end
		lcdfb_pkg::CMD_REFRESH: begin
			rs.kind = lcdfb_pkg::KIND_CMD;
			rs.byte_a = lcdfb_pkg::HOME_CMD;
			rs.last = 1'b0;
			frames_due.push_back(rs);
			for (int g = 0; g < GROUPS; g++) begin
				for (int j = 0; j < 4; j++) begin
					n = 4 * g + j;
					seg = 2'((n / COLUMNS) % 4);
					// DDRAM lines 0,1,2,3 hold rows 0,2,1,3: swap the two bits.
					ram_row = {seg[0], seg[1]};
					grp[j] = char_ram[int'(ram_row) * COLUMNS + n % COLUMNS];
				end
				rs = '0;
				rs.kind = lcdfb_pkg::KIND_DATA;
				rs.byte_a = grp[0];
				rs.byte_b = grp[1];
				rs.byte_c = grp[2];
				rs.byte_d = grp[3];
				rs.last = (g == GROUPS - 1);
				frames_due.push_back(rs);
			end
		end
		endcase
	endtask

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (char_ram[i])
				char_ram[i] = '0;
			cur_col = '0;
			cur_row = '0;
			frames_due.delete();
			fail_count = 0;
			checked_count = 0;
		end else begin
			if (push && !full)
				predict_command(command, char_code, col, row);
			if (pop && !empty) begin
				if (frames_due.size() == 0) begin
					$error("result transaction with no expectation waiting");
					fail_count++;
				end else begin
					oldest = frames_due.pop_front();
					compare_field("kind", 8'(oldest.kind), 8'(kind));
					compare_field("status", 8'(oldest.status), 8'(status));
					compare_field("byte_a", oldest.byte_a, byte_a);
					compare_field("byte_b", oldest.byte_b, byte_b);
					compare_field("byte_c", oldest.byte_c, byte_c);
					compare_field("byte_d", oldest.byte_d, byte_d);
					compare_field("last", 8'(oldest.last), 8'(last));
					checked_count++;
				end
			end
		end
		pending_count = frames_due.size();
	end

endmodule

/* tb/sv/char_lcd_text_frame_buffer_unit_test.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_frame_buffer_unit_test
// Drives command transactions into the LCD text frame buffer under several
// idling patterns and a long output hold-off; the checker grades the results.
// ----------------------------------------------------------------------------
module char_lcd_text_frame_buffer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS      = 20;
	localparam int PERIOD       = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4 * COLUMNS + 40;
	localparam int LONG_HOLD    = 300;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic       full;
	logic [1:0] command   = lcdfb_pkg::CMD_PUT;
	logic [7:0] char_code = '0;
	logic [7:0] col       = '0;
	logic [7:0] row       = '0;
	logic       empty;
	logic       pop       = 1'b0;
	logic [1:0] kind;
	logic       status;
	logic [7:0] byte_a;
	logic [7:0] byte_b;
	logic [7:0] byte_c;
	logic [7:0] byte_d;
	logic       last;
	int         fail_count;
	int         pending_count;
	int         checked_count;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int cmds_sent      = 0;
	int refreshes_sent = 0;
	int clears_sent    = 0;
	int cursor_sent    = 0;
	int full_cycles    = 0;

	char_lcd_text_frame_buffer_unit #(.COLUMNS(COLUMNS)) i_dut (.*);

	lcdfb_text_checker #(.COLUMNS(COLUMNS)) i_checker (.*);

	always #(PERIOD / 2) clk = ~clk;

	task automatic send_command(logic [1:0] cmd, logic [7:0] ch, logic [7:0] c,
			logic [7:0] r);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		char_code <= ch;
		col <= c;
		row <= r;
		@(posedge clk);
		while (full) begin
			full_cycles++;
			@(posedge clk);
		end
		cmds_sent++;
		case (cmd)
		lcdfb_pkg::CMD_REFRESH: refreshes_sent++;
		lcdfb_pkg::CMD_CLEAR:   clears_sent++;
		lcdfb_pkg::CMD_SETCUR:  cursor_sent++;
		default: ;
		endcase
	endtask

	// Mostly character writes with a bias toward the remapped letters and
	// newlines; cursor moves are mostly legal, with edge and wild positions.
	task automatic send_random_command();
		logic [1:0] cmd;
		logic [7:0] ch;
		logic [7:0] c;
		logic [7:0] r;
		int         pick;
		int         sub;
		ch = 8'($urandom);
		c = 8'($urandom);
		r = 8'($urandom);
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 99);
		if (pick < 58) begin
			cmd = lcdfb_pkg::CMD_PUT;
			if (sub < 15) begin
				case ($urandom_range(0, 6))
				0: ch = 8'ha5;
				1: ch = 8'h86;
				2: ch = 8'ha9;
				3: ch = 8'ha2;
				4: ch = 8'h88;
				5: ch = 8'he4;
				default: ch = 8'h98;
				endcase
			end else if (sub < 25) begin
				ch = lcdfb_pkg::NEWLINE;
			end
		end else if (pick < 78) begin
			cmd = lcdfb_pkg::CMD_SETCUR;
			if (sub < 70) begin
				c = 8'($urandom_range(0, COLUMNS - 1));
				r = 8'($urandom_range(0, 3));
			end else if (sub < 85) begin
				c = 8'($urandom_range(COLUMNS - 1, COLUMNS));
				r = 8'($urandom_range(3, 4));
			end
		end else if (pick < 94) begin
			cmd = lcdfb_pkg::CMD_REFRESH;
		end else begin
			cmd = lcdfb_pkg::CMD_CLEAR;
		end
		send_command(cmd, ch, c, r);
	endtask

	// Output side: random stalls, plus a long hold-off whenever one is asked.
	initial begin
		int holds_done;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				for (int k = 0; k < LONG_HOLD; k++) begin
					pop <= 1'b0;
					@(negedge clk);
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: store still zero from reset, glyph remapping,
		// newline, wraps at the last column and the last row, rejected
		// cursor positions, clear and refreshes around them.
		send_command(lcdfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'h41, 8'hff, 8'hff);
		send_command(lcdfb_pkg::CMD_PUT, 8'ha5, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'h86, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'ha9, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'ha2, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'h88, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'he4, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'h98, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, lcdfb_pkg::NEWLINE, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'hff, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'h00, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_SETCUR, 8'h00, 8'(COLUMNS - 1), 8'd3);
		send_command(lcdfb_pkg::CMD_PUT, 8'h5a, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_SETCUR, 8'hff, 8'(COLUMNS), 8'd0);
		send_command(lcdfb_pkg::CMD_SETCUR, 8'h00, 8'd0, 8'd4);
		send_command(lcdfb_pkg::CMD_SETCUR, 8'h00, 8'hff, 8'hff);
		send_command(lcdfb_pkg::CMD_SETCUR, 8'h00, 8'd0, 8'd3);
		send_command(lcdfb_pkg::CMD_PUT, lcdfb_pkg::NEWLINE, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_PUT, 8'h7f, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_REFRESH, 8'hff, 8'hff, 8'hff);
		send_command(lcdfb_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 8'h00);
		send_command(lcdfb_pkg::CMD_SETCUR, 8'h00, 8'd0, 8'd0);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (68) send_random_command();

		// Output held off while refreshes keep arriving, so the block backs up.
		hold_requests++;
		repeat (4) send_command(lcdfb_pkg::CMD_REFRESH, 8'h00, 8'h00, 8'h00);
		repeat (20) send_random_command();

		send_idle_pct = 51;
		recv_stall_pct = 0;
		repeat (68) send_random_command();

		send_idle_pct = 0;
		recv_stall_pct = 51;
		repeat (68) send_random_command();

		send_idle_pct = 33;
		recv_stall_pct = 33;
		repeat (68) send_random_command();

		@(negedge clk);
		push <= 1'b0;
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands: %0d refreshes, %0d clears, %0d cursor moves.",
				cmds_sent, refreshes_sent, clears_sent, cursor_sent);
		$display("Checked %0d result transactions; input held back by full for %0d cycles.",
				checked_count, full_cycles);
		if (fail_count == 0 && pending_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
